### hw/rtl/bhfs_pkg.sv
// Shared types, widths, command codes and helpers for the byte histogram block.
package bhfs_pkg;

   localparam int COUNT_WIDTH  = 32;
   localparam int SYM_W        = 8;
   localparam int NUM_SYMBOLS  = 1 << SYM_W;
   localparam int DIST_W       = SYM_W + 1;
   localparam int OUT_CNT_W    = 32;
   localparam int WIDE_W       = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;

   typedef logic [1:0]             cmd_type;
   typedef logic [SYM_W-1:0]       sym_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [DIST_W-1:0]      dist_type;
   typedef logic [OUT_CNT_W-1:0]   out_cnt_type;

   localparam cmd_type CMD_COUNT = 2'd0;
   localparam cmd_type CMD_READ  = 2'd1;
   localparam cmd_type CMD_CLEAR = 2'd2;

   // Counts wider than the result field stop at its all-ones value.
   function automatic out_cnt_type clip_count(input count_type c);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(c);
      if (wide > WIDE_W'({OUT_CNT_W{1'b1}})) begin
         return '1;
      end
      return wide[OUT_CNT_W-1:0];
   endfunction

endpackage

### hw/rtl/bhfs_req_if.sv
// Request channel: command, symbol and position with valid/ready handshake.
interface bhfs_req_if import bhfs_pkg::*; ;
   logic    valid;
   logic    ready;
   cmd_type command;
   sym_type symbol;
   sym_type position;

   modport source (output valid, output command, output symbol, output position,
                   input ready);
   modport sink   (input valid, input command, input symbol, input position,
                   output ready);
endinterface

### hw/rtl/bhfs_rsp_if.sv
// Response channel: symbol, count, distinct total and flags with valid/ready handshake.
interface bhfs_rsp_if import bhfs_pkg::*; ;
   logic        valid;
   logic        ready;
   sym_type     out_symbol;
   out_cnt_type out_count;
   dist_type    distinct_total;
   logic        was_new;
   logic        position_valid;

   modport source (output valid, output out_symbol, output out_count,
                   output distinct_total, output was_new, output position_valid,
                   input ready);
   modport sink   (input valid, input out_symbol, input out_count,
                   input distinct_total, input was_new, input position_valid,
                   output ready);
endinterface

### hw/rtl/byte_histogram_first_seen_order.sv
// From the accepting edge to the response register: a count passes RD1 and FIN, a read
// RD1, RD2 and FIN (order-list read, then count read of the symbol found there), a clear/unused FIN only.
// One request in flight; the next is taken the cycle after the response is loaded, and
// FIN holds the request while the previous response still waits to be taken.
// Reset (synchronous) clears seen flags, distinct total, sequencer and response valid;
// the count and order memories are not cleared.
module byte_histogram_first_seen_order import bhfs_pkg::*; (
   input logic     clock,
   input logic     reset,
   bhfs_req_if.sink   req,
   bhfs_rsp_if.source rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD1  = 2'd1;
   localparam logic [1:0] ST_RD2  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0] state_ff, state_in;
   cmd_type    cmd_ff, cmd_in;
   sym_type    sym_ff, sym_in;
   sym_type    pos_ff, pos_in;
   logic [NUM_SYMBOLS-1:0] seen_ff, seen_in;
   dist_type   dist_ff, dist_in;

   logic        rsp_valid_ff, rsp_valid_in;
   sym_type     rsp_sym_ff, rsp_sym_in;
   out_cnt_type rsp_cnt_ff, rsp_cnt_in;
   dist_type    rsp_dist_ff, rsp_dist_in;
   logic        rsp_new_ff, rsp_new_in;
   logic        rsp_pvalid_ff, rsp_pvalid_in;

   logic      accept;
   logic      slot_free;
   logic      cnt_wr_en, cnt_rd_en;
   sym_type   cnt_rd_addr;
   count_type cnt_wr_data, cnt_rd_data;
   logic      ord_wr_en, ord_rd_en;
   sym_type   ord_rd_data;
   logic      is_new;
   logic      pos_ok;
   count_type cnt_next;

   assign req.ready  = (state_ff == ST_IDLE);
   assign accept     = req.valid && req.ready;
   assign slot_free  = !rsp_valid_ff || rsp.ready;

   assign is_new   = !seen_ff[sym_ff];
   assign pos_ok   = DIST_W'(pos_ff) < dist_ff;
   assign cnt_next = is_new ? COUNT_WIDTH'(1) :
                     ((&cnt_rd_data) ? cnt_rd_data : cnt_rd_data + COUNT_WIDTH'(1));

   // Count path reads by symbol at accept; read path reads by the symbol from the order list.
   assign cnt_rd_en   = accept || ((state_ff == ST_RD1) && (cmd_ff == CMD_READ));
   assign cnt_rd_addr = (state_ff == ST_IDLE) ? req.symbol : ord_rd_data;
   assign ord_rd_en   = accept;

   assign cnt_wr_en   = (state_ff == ST_FIN) && slot_free && (cmd_ff == CMD_COUNT);
   assign cnt_wr_data = cnt_next;
   assign ord_wr_en   = cnt_wr_en && is_new;

   bhfs_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_SYMBOLS)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (sym_ff),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   bhfs_ram #(.WIDTH(SYM_W), .DEPTH(NUM_SYMBOLS)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_wr_en),
      .wr_addr (dist_ff[SYM_W-1:0]),
      .wr_data (sym_ff),
      .rd_en   (ord_rd_en),
      .rd_addr (req.position),
      .rd_data (ord_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sym_in        = sym_ff;
      pos_in        = pos_ff;
      seen_in       = seen_ff;
      dist_in       = dist_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_sym_in    = rsp_sym_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_pvalid_in = rsp_pvalid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req.command;
               sym_in = req.symbol;
               pos_in = req.position;
               if ((req.command == CMD_COUNT) || (req.command == CMD_READ)) begin
                  state_in = ST_RD1;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_RD1: begin
            state_in = (cmd_ff == CMD_READ) ? ST_RD2 : ST_FIN;
         end
         ST_RD2: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (slot_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_sym_in    = '0;
               rsp_cnt_in    = '0;
               rsp_new_in    = 1'b0;
               rsp_pvalid_in = 1'b0;
               rsp_dist_in   = dist_ff;
               unique case (cmd_ff)
                  CMD_COUNT: begin
                     rsp_sym_in = sym_ff;
                     rsp_cnt_in = clip_count(cnt_next);
                     rsp_new_in = is_new;
                     if (is_new) begin
                        seen_in[sym_ff] = 1'b1;
                        if (dist_ff < DIST_W'(NUM_SYMBOLS)) begin
                           dist_in = dist_ff + DIST_W'(1);
                        end
                     end
                     rsp_dist_in = dist_in;
                  end
                  CMD_READ: begin
                     if (pos_ok) begin
                        rsp_sym_in    = ord_rd_data;
                        rsp_cnt_in    = clip_count(cnt_rd_data);
                        rsp_pvalid_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     seen_in     = '0;
                     dist_in     = '0;
                     rsp_dist_in = '0;
                  end
                  default: begin
                     // unused code: report the current total only
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seen_ff      <= '0;
         dist_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         dist_ff      <= dist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      sym_ff        <= sym_in;
      pos_ff        <= pos_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_symbol     = rsp_sym_ff;
   assign rsp.out_count      = rsp_cnt_ff;
   assign rsp.distinct_total = rsp_dist_ff;
   assign rsp.was_new        = rsp_new_ff;
   assign rsp.position_valid = rsp_pvalid_ff;

endmodule

### hw/rtl/bhfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bhfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AddrW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### tb/byte_histogram_first_seen_order_tb.sv
// Self-checking testbench for the byte histogram with first-seen order.
`timescale 1ns / 1ps

module byte_histogram_first_seen_order_tb;
   import bhfs_pkg::*;

   localparam cmd_type CMD_UNUSED = 2'd3;
   localparam int      HOLD_CYCLES = 300;
   localparam int      DRAIN_CYCLES = 12;

   typedef struct packed {
      sym_type     sym;
      out_cnt_type count;
      dist_type    total;
      logic        was_new;
      logic        pos_valid;
   } hist_result_type;

   typedef struct packed {
      cmd_type         cmd;
      sym_type         sym;
      sym_type         pos;
      logic            typed;
      hist_result_type res;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bhfs_req_if req_ch ();
   bhfs_rsp_if rsp_ch ();

   byte_histogram_first_seen_order u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #5 clock = ~clock;

   // predictor state
   logic      seen [NUM_SYMBOLS];
   count_type tally [NUM_SYMBOLS];
   sym_type   arrival_order [NUM_SYMBOLS];
   dist_type  distinct_seen;

   hist_result_type pending_results [$];
   int              errors = 0;
   int              responses_checked = 0;
   bit              calm = 1'b0;

   // typed rows: fixed expectation; others come from the predictor
   directed_row_type directed_rows [19] = '{
      '{CMD_READ,   8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 9'd0, 1'b0, 1'b0}},
      '{CMD_UNUSED, 8'hff, 8'hff, 1'b1, '{8'h00, 32'd0, 9'd0, 1'b0, 1'b0}},
      '{CMD_COUNT,  8'h00, 8'hff, 1'b1, '{8'h00, 32'd1, 9'd1, 1'b1, 1'b0}},
      '{CMD_COUNT,  8'hff, 8'h00, 1'b1, '{8'hff, 32'd1, 9'd2, 1'b1, 1'b0}},
      '{CMD_COUNT,  8'h00, 8'h00, 1'b1, '{8'h00, 32'd2, 9'd2, 1'b0, 1'b0}},
      '{CMD_READ,   8'hff, 8'h00, 1'b1, '{8'h00, 32'd2, 9'd2, 1'b0, 1'b1}},
      '{CMD_READ,   8'h00, 8'h01, 1'b1, '{8'hff, 32'd1, 9'd2, 1'b0, 1'b1}},
      '{CMD_READ,   8'h00, 8'h02, 1'b1, '{8'h00, 32'd0, 9'd2, 1'b0, 1'b0}},
      '{CMD_READ,   8'h00, 8'hff, 1'b1, '{8'h00, 32'd0, 9'd2, 1'b0, 1'b0}},
      '{CMD_COUNT,  8'haa, 8'h55, 1'b0, '0},
      '{CMD_COUNT,  8'h55, 8'haa, 1'b0, '0},
      '{CMD_COUNT,  8'haa, 8'h00, 1'b0, '0},
      '{CMD_READ,   8'h00, 8'h02, 1'b0, '0},
      '{CMD_UNUSED, 8'h00, 8'h00, 1'b0, '0},
      '{CMD_CLEAR,  8'hff, 8'hff, 1'b1, '{8'h00, 32'd0, 9'd0, 1'b0, 1'b0}},
      '{CMD_READ,   8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 9'd0, 1'b0, 1'b0}},
      '{CMD_COUNT,  8'hff, 8'h00, 1'b1, '{8'hff, 32'd1, 9'd1, 1'b1, 1'b0}},
      '{CMD_READ,   8'h00, 8'h00, 1'b1, '{8'hff, 32'd1, 9'd1, 1'b0, 1'b1}},
      '{CMD_CLEAR,  8'h00, 8'h00, 1'b1, '{8'h00, 32'd0, 9'd0, 1'b0, 1'b0}}
   };

   function automatic out_cnt_type visible_count(input count_type c);
      if (64'(c) > 64'hffff_ffff) begin
         return '1;
      end
      return out_cnt_type'(c);
   endfunction

   // Applies one request to the local copy of the table and returns its result.
   function automatic hist_result_type histogram_apply(input cmd_type c, input sym_type s,
                                                       input sym_type p);
      hist_result_type r;
      r = '0;
      unique case (c)
         CMD_COUNT: begin
            if (!seen[s]) begin
               seen[s] = 1'b1;
               tally[s] = count_type'(1);
               arrival_order[distinct_seen[SYM_W-1:0]] = s;
               if (distinct_seen < dist_type'(NUM_SYMBOLS)) begin
                  distinct_seen++;
               end
               r.was_new = 1'b1;
            end else if (tally[s] != '1) begin
               tally[s]++;
            end
            r.sym   = s;
            r.count = visible_count(tally[s]);
         end
         CMD_READ: begin
            if (dist_type'(p) < distinct_seen) begin
               r.sym       = arrival_order[p];
               r.count     = visible_count(tally[arrival_order[p]]);
               r.pos_valid = 1'b1;
            end
         end
         CMD_CLEAR: begin
            foreach (seen[i]) seen[i] = 1'b0;
            distinct_seen = '0;
         end
         default: ;
      endcase
      r.total = distinct_seen;
      return r;
   endfunction

   // Entered and left at a falling edge.
   task automatic send_request(input cmd_type c, input sym_type s, input sym_type p,
                               input logic typed, input hist_result_type fixed);
      hist_result_type predicted;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.command  <= c;
      req_ch.symbol   <= s;
      req_ch.position <= p;
      do @(posedge clock); while (!req_ch.ready);
      predicted = histogram_apply(c, s, p);
      pending_results.push_back(typed ? fixed : predicted);
      @(negedge clock);
   endtask

   task automatic send_random_mix();
      int      pick;
      sym_type s;
      sym_type p;
      pick = $urandom_range(0, 99);
      s = ($urandom_range(0, 1) == 0) ? sym_type'($urandom_range(0, 7))
                                      : sym_type'($urandom_range(0, 255));
      // mostly in range, including the first invalid slot
      p = ($urandom_range(0, 4) != 0)
          ? sym_type'($urandom_range(0, (distinct_seen > 255) ? 255 : int'(distinct_seen)))
          : sym_type'($urandom_range(0, 255));
      if (pick < 60) begin
         send_request(CMD_COUNT, s, p, 1'b0, '0);
      end else if (pick < 96) begin
         send_request(CMD_READ, s, p, 1'b0, '0);
      end else if (pick < 98) begin
         send_request(CMD_CLEAR, s, p, 1'b0, '0);
      end else begin
         send_request(CMD_UNUSED, s, p, 1'b0, '0);
      end
   endtask

   // stimulus
   initial begin
      sym_type sweep [NUM_SYMBOLS];
      sym_type tmp;
      int      j;
      foreach (seen[i]) begin
         seen[i] = 1'b0;
         tally[i] = '0;
         arrival_order[i] = '0;
      end
      distinct_seen    = '0;
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_COUNT;
      req_ch.symbol    = '0;
      req_ch.position  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].cmd, directed_rows[i].sym, directed_rows[i].pos,
                      directed_rows[i].typed, directed_rows[i].res);
      end

      repeat (350) send_random_mix();

      // fill the table with every byte in shuffled order, then read the last slot and mix random reads and counts
      foreach (sweep[k]) sweep[k] = sym_type'(k);
      for (int k = NUM_SYMBOLS - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         tmp = sweep[k];
         sweep[k] = sweep[j];
         sweep[j] = tmp;
      end
      send_request(CMD_CLEAR, 8'h00, 8'h00, 1'b0, '0);
      foreach (sweep[k]) send_request(CMD_COUNT, sweep[k], sym_type'($urandom_range(0, 255)),
                                      1'b0, '0);
      send_request(CMD_READ, 8'h00, 8'hff, 1'b0, '0);
      repeat (40) begin
         if ($urandom_range(0, 2) == 0) begin
            send_request(CMD_COUNT, sym_type'($urandom_range(0, 255)), 8'h00, 1'b0, '0);
         end else begin
            send_request(CMD_READ, 8'h00, sym_type'($urandom_range(0, 255)), 1'b0, '0);
         end
      end

      repeat (160) send_random_mix();
      calm = 1'b1;
      repeat (120) send_random_mix();
      req_ch.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // response side back-pressure, with one long hold to fill the block
   initial begin
      int  stall_left;
      bit  long_hold_done;
      stall_left     = 0;
      long_hold_done = 1'b0;
      rsp_ch.ready   = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!long_hold_done && responses_checked >= 150) begin
            long_hold_done = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      hist_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_checked++;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.out_symbol !== want.sym) begin
               $error("out_symbol expected %0h got %0h", want.sym, rsp_ch.out_symbol);
               errors++;
            end
            if (rsp_ch.out_count !== want.count) begin
               $error("out_count expected %0d got %0d", want.count, rsp_ch.out_count);
               errors++;
            end
            if (rsp_ch.distinct_total !== want.total) begin
               $error("distinct_total expected %0d got %0d", want.total,
                      rsp_ch.distinct_total);
               errors++;
            end
            if (rsp_ch.was_new !== want.was_new) begin
               $error("was_new expected %0b got %0b", want.was_new, rsp_ch.was_new);
               errors++;
            end
            if (rsp_ch.position_valid !== want.pos_valid) begin
               $error("position_valid expected %0b got %0b", want.pos_valid,
                      rsp_ch.position_valid);
               errors++;
            end
         end
      end
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/bhfs_pkg.sv
hw/rtl/bhfs_req_if.sv
hw/rtl/bhfs_rsp_if.sv
hw/rtl/bhfs_ram.sv
hw/rtl/byte_histogram_first_seen_order.sv
tb/byte_histogram_first_seen_order_tb.sv
